// ===== src/itcp_pkg.sv =====
package itcp_pkg;

    typedef logic [7:0] char_t;
    typedef logic [8:0] octet_t;
    typedef logic [2:0] dot_count_t;

    // Result codes, as seen on the verdict channel
    typedef enum logic [2:0] {
        VERDICT_INVALID = 3'd0,
        VERDICT_CLASS_A = 3'd1,
        VERDICT_CLASS_B = 3'd2,
        VERDICT_CLASS_C = 3'd3,
        VERDICT_OTHER   = 3'd4
    } verdict_t;

    localparam char_t CHAR_ZERO = 8'h30;
    localparam char_t CHAR_NINE = 8'h39;
    localparam char_t CHAR_DOT  = 8'h2E;

    localparam octet_t     OCTET_MAX  = 9'd255;
    localparam octet_t     OCTET_SAT  = 9'd256;
    localparam dot_count_t DOT_SAT    = 3'd7;
    localparam dot_count_t DOT_NEEDED = 3'd3;

    localparam logic [7:0] CLASS_A_LAST = 8'd125;
    localparam logic [7:0] LOOPBACK_NET = 8'd126;
    localparam logic [7:0] CLASS_B_LOW  = 8'd128;
    localparam logic [7:0] CLASS_B_HIGH = 8'd191;
    localparam logic [7:0] CLASS_C_LOW  = 8'd192;
    localparam logic [7:0] CLASS_C_HIGH = 8'd223;

    // Class of a well-formed address from its first octet, and for net 126 from whether the rest is zero
    function automatic verdict_t classify(input logic [7:0] first, input logic rest_zero);
        verdict_t v;
        if ((first != 8'd0 && first <= CLASS_A_LAST) || (first == LOOPBACK_NET && rest_zero))
            v = VERDICT_CLASS_A;
        else if (first >= CLASS_B_LOW && first <= CLASS_B_HIGH)
            v = VERDICT_CLASS_B;
        else if (first >= CLASS_C_LOW && first <= CLASS_C_HIGH)
            v = VERDICT_CLASS_C;
        else
            v = VERDICT_OTHER;
        return v;
    endfunction

endpackage

// ===== src/itcp_char_if.sv =====
interface itcp_char_if;
    import itcp_pkg::*;

    logic  valid;
    logic  ready;
    char_t char_code;
    logic  last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== src/itcp_verdict_if.sv =====
interface itcp_verdict_if;
    import itcp_pkg::*;

    logic     valid;
    logic     ready;
    verdict_t verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

// ===== src/ipv4_text_class_parser_core.sv =====
// The last character waits in the input register, then its verdict in the result register.
// Throughput: one character per cycle; the input register drains into the state every cycle
// unless it holds a last character while the verdict register is still waiting to be taken.
// Reset: rst_n asynchronously clears both valid flags and the parse state; the parse state
// also returns to its reset value after each last character.
module ipv4_text_class_parser_core (
    input  logic                  clk,
    input  logic                  rst_n,
    itcp_char_if.sink             chars,
    itcp_verdict_if.source        verdicts
);
    import itcp_pkg::*;

    // Input register
    logic  s1_valid_reg;
    char_t s1_char_reg;
    logic  s1_last_reg;

    // Parse state
    octet_t     octet_value_reg, octet_value_next;
    logic       octet_empty_reg, octet_empty_next;
    logic       lead_zero_reg, lead_zero_next;
    dot_count_t dot_count_reg, dot_count_next;
    logic [7:0] first_octet_reg, first_octet_next;
    logic       rest_zero_reg, rest_zero_next;
    logic       error_seen_reg, error_seen_next;

    // Result register
    logic     out_valid_reg;
    verdict_t verdict_reg, verdict_next;

    logic s1_advance;
    logic s1_fire;
    logic out_free;

    // Per-character intermediate values
    logic        is_digit;
    logic [3:0]  digit;
    logic [11:0] octet_prod;
    octet_t      ov1;
    logic        empty1, lz1, rz1, err1, err2, rz2;
    dot_count_t  dc1;
    logic [7:0]  fo1, fo2;
    logic        octet_bad_pre, octet_bad_post;

    // Handshake: a non-final character never needs the result register
    assign out_free       = !out_valid_reg || verdicts.ready;
    assign s1_advance     = !s1_last_reg || out_free;
    assign s1_fire        = s1_valid_reg && s1_advance;
    assign chars.ready    = !s1_valid_reg || s1_advance;
    assign verdicts.valid = out_valid_reg;
    assign verdicts.verdict = verdict_reg;

    // Character step, then close-out on the last character
    always_comb
    begin
        is_digit   = (s1_char_reg >= CHAR_ZERO) && (s1_char_reg <= CHAR_NINE);
        digit      = s1_char_reg[3:0];
        octet_prod = ({3'b000, octet_value_reg} << 3) + ({3'b000, octet_value_reg} << 1)
                     + {8'd0, digit};

        octet_bad_pre = octet_empty_reg || (octet_value_reg > OCTET_MAX)
                        || (lead_zero_reg && octet_value_reg != 9'd0);

        ov1    = octet_value_reg;
        empty1 = octet_empty_reg;
        lz1    = lead_zero_reg;
        dc1    = dot_count_reg;
        fo1    = first_octet_reg;
        rz1    = rest_zero_reg;
        err1   = error_seen_reg;

        if (is_digit)
        begin
            if (octet_empty_reg)
                lz1 = (digit == 4'd0);
            ov1    = (octet_prod > {3'b000, OCTET_SAT}) ? OCTET_SAT : octet_prod[8:0];
            empty1 = 1'b0;
        end
        else if (s1_char_reg == CHAR_DOT)
        begin
            err1 = error_seen_reg || octet_bad_pre;
            if (dot_count_reg == 3'd0)
                fo1 = octet_value_reg[7:0];
            else if (octet_value_reg != 9'd0)
                rz1 = 1'b0;
            if (dot_count_reg < DOT_SAT)
                dc1 = dot_count_reg + 3'd1;
            ov1    = 9'd0;
            empty1 = 1'b1;
            lz1    = 1'b0;
        end
        else
        begin
            err1 = 1'b1;
        end

        // Closing the final octet
        octet_bad_post = empty1 || (ov1 > OCTET_MAX) || (lz1 && ov1 != 9'd0);
        err2 = err1 || octet_bad_post || (dc1 != DOT_NEEDED);
        fo2  = (dc1 == 3'd0) ? ov1[7:0] : fo1;
        rz2  = (dc1 != 3'd0 && ov1 != 9'd0) ? 1'b0 : rz1;
        verdict_next = err2 ? VERDICT_INVALID : classify(fo2, rz2);

        if (s1_last_reg)
        begin
            octet_value_next = 9'd0;
            octet_empty_next = 1'b1;
            lead_zero_next   = 1'b0;
            dot_count_next   = 3'd0;
            first_octet_next = 8'd0;
            rest_zero_next   = 1'b1;
            error_seen_next  = 1'b0;
        end
        else
        begin
            octet_value_next = ov1;
            octet_empty_next = empty1;
            lead_zero_next   = lz1;
            dot_count_next   = dc1;
            first_octet_next = fo1;
            rest_zero_next   = rz1;
            error_seen_next  = err1;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (chars.ready)
            s1_valid_reg <= chars.valid;
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            s1_char_reg <= chars.char_code;
            s1_last_reg <= chars.last_char;
        end
    end

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octet_value_reg <= 9'd0;
            octet_empty_reg <= 1'b1;
            lead_zero_reg   <= 1'b0;
            dot_count_reg   <= 3'd0;
            first_octet_reg <= 8'd0;
            rest_zero_reg   <= 1'b1;
            error_seen_reg  <= 1'b0;
        end
        else if (s1_fire)
        begin
            octet_value_reg <= octet_value_next;
            octet_empty_reg <= octet_empty_next;
            lead_zero_reg   <= lead_zero_next;
            dot_count_reg   <= dot_count_next;
            first_octet_reg <= first_octet_next;
            rest_zero_reg   <= rest_zero_next;
            error_seen_reg  <= error_seen_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_fire && s1_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
            verdict_reg <= verdict_next;
    end

    // Checks
    a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |-> s1_last_reg && out_valid_reg && !verdicts.ready)
        else $error("input register stalled without a pending verdict");

    a_state_cleared_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> dot_count_reg == 3'd0 && octet_empty_reg
                                   && !error_seen_reg && rest_zero_reg)
        else $error("parse state not cleared after last character");

    a_verdict_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !$past(out_valid_reg) |-> $past(s1_fire && s1_last_reg))
        else $error("verdict raised without a last character");

    a_verdict_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> verdict_reg <= VERDICT_OTHER)
        else $error("verdict code out of range");

endmodule

// ===== tb/ipv4_text_class_parser_core_test.sv =====
`timescale 1ns / 100ps

module ipv4_text_class_parser_core_test;
    import itcp_pkg::*;

    localparam int DIRECTED_COUNT = 26;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int STALL_PERCENT  = 38;
    // Random part runs with no idling on either side for these item counts
    localparam int STEADY_FROM    = DIRECTED_COUNT + 700;
    localparam int STEADY_TO      = DIRECTED_COUNT + 1000;

    // One character per row; a pinned verdict is checked as typed here
    typedef struct packed {
        char_t    code;
        logic     last;
        logic     pinned;
        verdict_t verdict;
    } char_row_t;

    localparam char_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
        // single-character strings: extreme bytes and a lone dot
        '{8'hFF, 1'b1, 1'b1, VERDICT_INVALID},
        '{8'h00, 1'b1, 1'b1, VERDICT_INVALID},
        '{CHAR_DOT, 1'b1, 1'b1, VERDICT_INVALID},
        // plain class A address
        '{"1", 1'b0, 1'b0, VERDICT_INVALID},
        '{CHAR_DOT, 1'b0, 1'b0, VERDICT_INVALID},
        '{"2", 1'b0, 1'b0, VERDICT_INVALID},
        '{CHAR_DOT, 1'b0, 1'b0, VERDICT_INVALID},
        '{"3", 1'b0, 1'b0, VERDICT_INVALID},
        '{CHAR_DOT, 1'b0, 1'b0, VERDICT_INVALID},
        '{"4", 1'b1, 1'b1, VERDICT_CLASS_A},
        // four dots, all octets empty
        '{CHAR_DOT, 1'b0, 1'b0, VERDICT_INVALID},
        '{CHAR_DOT, 1'b0, 1'b0, VERDICT_INVALID},
        '{CHAR_DOT, 1'b0, 1'b0, VERDICT_INVALID},
        '{CHAR_DOT, 1'b1, 1'b1, VERDICT_INVALID},
        // all-zero address with a doubled zero at the end
        '{"0", 1'b0, 1'b0, VERDICT_INVALID},
        '{CHAR_DOT, 1'b0, 1'b0, VERDICT_INVALID},
        '{"0", 1'b0, 1'b0, VERDICT_INVALID},
        '{CHAR_DOT, 1'b0, 1'b0, VERDICT_INVALID},
        '{"0", 1'b0, 1'b0, VERDICT_INVALID},
        '{CHAR_DOT, 1'b0, 1'b0, VERDICT_INVALID},
        '{"0", 1'b0, 1'b0, VERDICT_INVALID},
        '{"0", 1'b1, 1'b0, VERDICT_INVALID},
        // long digit run, no dots
        '{"9", 1'b0, 1'b0, VERDICT_INVALID},
        '{"9", 1'b0, 1'b0, VERDICT_INVALID},
        '{"9", 1'b0, 1'b0, VERDICT_INVALID},
        '{"9", 1'b1, 1'b1, VERDICT_INVALID}
    };

    // First-octet values at the class boundaries
    localparam int unsigned FIRST_MARKS [0:10] = '{
        0, 1, 125, 126, 127, 128, 191, 192, 223, 224, 255
    };

    logic clk;
    logic rst_n;
    bit   steady = 1'b0;

    itcp_char_if    chars ();
    itcp_verdict_if verdicts ();

    ipv4_text_class_parser_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (chars),
        .verdicts (verdicts)
    );

    // Parser state mirror
    octet_t     octet_val;
    logic       octet_blank;
    logic       zero_led;
    dot_count_t dots;
    logic [7:0] first_val;
    logic       tail_zero;
    logic       fault;

    verdict_t pending_verdicts [$];
    char_t    spell_q [$];
    int       mismatch_count = 0;
    int       chars_sent     = 0;
    int       quiet_cycles   = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic clear_parse();
        octet_val   = '0;
        octet_blank = 1'b1;
        zero_led    = 1'b0;
        dots        = '0;
        first_val   = '0;
        tail_zero   = 1'b1;
        fault       = 1'b0;
    endtask

    // Judge the octet just finished and record it
    task automatic seal_octet();
        if (octet_blank || octet_val > OCTET_MAX || (zero_led && octet_val != 0))
            fault = 1'b1;
        if (dots == 0)
            first_val = octet_val[7:0];
        else if (octet_val != 0)
            tail_zero = 1'b0;
    endtask

    function automatic verdict_t class_of(input logic [7:0] lead, input logic zeros_after);
        if (lead inside {[8'd1:CLASS_A_LAST]} || (lead == LOOPBACK_NET && zeros_after))
            return VERDICT_CLASS_A;
        if (lead inside {[CLASS_B_LOW:CLASS_B_HIGH]})
            return VERDICT_CLASS_B;
        if (lead inside {[CLASS_C_LOW:CLASS_C_HIGH]})
            return VERDICT_CLASS_C;
        return VERDICT_OTHER;
    endfunction

    // Advance the mirror by one character; a last character yields a verdict
    task automatic parse_char(input char_t code, input logic last,
                              output logic emits, output verdict_t verdict);
        int unsigned acc;
        emits   = 1'b0;
        verdict = VERDICT_INVALID;
        if (code >= CHAR_ZERO && code <= CHAR_NINE)
        begin
            if (octet_blank)
                zero_led = (code == CHAR_ZERO);
            acc = int'(octet_val) * 10 + int'(code - CHAR_ZERO);
            octet_val   = (acc > OCTET_SAT) ? OCTET_SAT : octet_t'(acc);
            octet_blank = 1'b0;
        end
        else if (code == CHAR_DOT)
        begin
            seal_octet();
            if (dots != DOT_SAT)
                dots = dots + 1'b1;
            octet_val   = '0;
            octet_blank = 1'b1;
            zero_led    = 1'b0;
        end
        else
        begin
            fault = 1'b1;
        end
        if (last)
        begin
            seal_octet();
            if (dots != DOT_NEEDED)
                fault = 1'b1;
            emits   = 1'b1;
            verdict = fault ? VERDICT_INVALID : class_of(first_val, tail_zero);
            clear_parse();
        end
    endtask

    function automatic void append_number(input int unsigned n);
        string s;
        s = $sformatf("%0d", n);
        for (int k = 0; k < s.len(); k++)
            spell_q.push_back(char_t'(s[k]));
    endfunction

    // Mostly legal octets; most of the rest break one rule each, some are single digits
    task automatic append_octet(input logic is_first);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 78)
        begin
            if (is_first && $urandom_range(1))
                append_number(FIRST_MARKS[$urandom_range(10)]);
            else if (!is_first && $urandom_range(1))
                append_number(0);
            else
                append_number($urandom_range(255));
        end
        else if (r < 85)
        begin
            // leading zero; "00" stays legal
            spell_q.push_back(CHAR_ZERO);
            append_number($urandom_range(255));
        end
        else if (r < 90)
        begin
            append_number($urandom_range(999, 256));
        end
        else if (r < 94)
        begin
            repeat ($urandom_range(7, 4))
                spell_q.push_back(char_t'(CHAR_ZERO + $urandom_range(9)));
        end
        else if (r < 97)
        begin
            // empty octet
        end
        else
        begin
            append_number($urandom_range(9));
        end
    endtask

    // Build one string: four octets, wrong dot count / bad byte, or noise
    task automatic compose_string();
        int unsigned kind;
        int unsigned parts;
        kind = $urandom_range(99);
        spell_q.delete();
        if (kind < 70)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (k != 0)
                    spell_q.push_back(CHAR_DOT);
                append_octet(k == 0);
            end
        end
        else if (kind < 85)
        begin
            case ($urandom_range(4))
                0:       parts = 1;
                1:       parts = 2;
                2:       parts = 3;
                3:       parts = 5;
                default: parts = 9;
            endcase
            for (int k = 0; k < parts; k++)
            begin
                if (k != 0)
                    spell_q.push_back(CHAR_DOT);
                append_octet(k == 0);
            end
            if (spell_q.size() == 0)
                spell_q.push_back(char_t'(CHAR_ZERO + $urandom_range(9)));
            if ($urandom_range(1))
                spell_q[$urandom_range(spell_q.size() - 1)] = char_t'($urandom_range(255));
        end
        else
        begin
            repeat ($urandom_range(12, 1))
            begin
                case ($urandom_range(3))
                    0:       spell_q.push_back(char_t'(CHAR_ZERO + $urandom_range(9)));
                    1:       spell_q.push_back(CHAR_DOT);
                    default: spell_q.push_back(char_t'($urandom_range(255)));
                endcase
            end
        end
    endtask

    // Offer one character, with random idle cycles ahead of it
    task automatic drive_char(input char_t code, input logic last,
                              input logic pinned, input verdict_t pinned_verdict);
        logic     emits;
        verdict_t predicted;
        @(negedge clk);
        while (!steady && $urandom_range(99) < STALL_PERCENT)
        begin
            chars.valid     <= 1'b0;
            chars.char_code <= char_t'($urandom_range(255));
            chars.last_char <= 1'($urandom_range(1));
            @(negedge clk);
        end
        chars.valid     <= 1'b1;
        chars.char_code <= code;
        chars.last_char <= last;
        @(posedge clk);
        while (!chars.ready)
            @(posedge clk);
        parse_char(code, last, emits, predicted);
        if (emits)
            pending_verdicts.push_back(pinned ? pinned_verdict : predicted);
        chars_sent++;
    endtask

    // Verdict side backpressure
    always @(negedge clk)
        verdicts.ready <= rst_n && (steady || $urandom_range(99) >= STALL_PERCENT);

    // Verdict checker
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && verdicts.valid && verdicts.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch($sformatf("unexpected verdict %0d", verdicts.verdict));
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (verdicts.verdict !== want)
                    report_mismatch($sformatf("verdict %0d, wanted %0d",
                                              verdicts.verdict, want));
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((chars.valid && chars.ready) || (verdicts.valid && verdicts.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        chars.valid     = 1'b0;
        chars.char_code = '0;
        chars.last_char = 1'b0;
        verdicts.ready  = 1'b0;
        clear_parse();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows
        for (int i = 0; i < DIRECTED_COUNT; i++)
            drive_char(DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].last,
                       DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].verdict);

        // Random strings
        while (chars_sent < DIRECTED_COUNT + RANDOM_ITEMS)
        begin
            steady = (chars_sent >= STEADY_FROM && chars_sent < STEADY_TO);
            compose_string();
            foreach (spell_q[i])
                drive_char(spell_q[i], i == spell_q.size() - 1, 1'b0, VERDICT_INVALID);
        end
        steady = 1'b0;
        @(negedge clk);
        chars.valid <= 1'b0;

        // Drain, then let the pipeline settle
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
